>>> design/mmu_pkg.sv
package mmu_pkg;

  // Item opcodes
  typedef enum logic [1:0] {
    OP_WRITE_A = 2'd0,
    OP_WRITE_B = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [1:0] CFG_COLS_B    = 2'd2;

  localparam int CFG_W  = 4;
  localparam int ELEM_W = 32;
  localparam int POS_W  = 3;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int FRAC_W = 16;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_FLUSH1,
    ST_FLUSH2,
    ST_EMIT
  } state_t;

endpackage

>>> design/mmu_in_if.sv
interface mmu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [2:0]  row_index;
  logic [2:0]  col_index;
  logic [31:0] elem_value;

  modport source (output valid, op, row_index, col_index, elem_value, input ready);
  modport sink   (input valid, op, row_index, col_index, elem_value, output ready);
endinterface

>>> design/mmu_out_if.sv
interface mmu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] prod_value;
  logic [2:0]  prod_row;
  logic [2:0]  prod_col;
  logic        last_elem;

  modport source (output valid, prod_value, prod_row, prod_col, last_elem, input ready);
  modport sink   (input valid, prod_value, prod_row, prod_col, last_elem, output ready);
endinterface

>>> design/mmu_ram.sv
module mmu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/matrix_multiply_unit.sv
// Channel   Dir  Payload                                      Handshake
// in_ch     in   op, row_index, col_index, elem_value         valid/ready
// out_ch    out  prod_value, prod_row, prod_col, last_elem    valid/ready
// cfg       in   cfg_index, cfg_data                          cfg_write_en
//
// A load item is taken whenever it is offered while idle; loads may arrive back to back.
// A compute item works through the result elements in turn, waiting on any
// output stall: one multiply-accumulate per term on the shared multiplier,
// then RAM read, product register and final accumulate before each result.
// in_ch.ready is low while a compute runs. Synchronous reset, no clearing pass.
module matrix_multiply_unit
  import mmu_pkg::*;
#(
  parameter int MAX_DIM = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic [1:0] cfg_index,
  input  logic [3:0] cfg_data,
  mmu_in_if.sink     in_ch,
  mmu_out_if.source  out_ch
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int ACC_W  = PROD_W + $clog2(MAX_DIM + 1);
  localparam int TOP_LO = FRAC_W + ELEM_W - 1;

  // Last valid index for a dimension register
  function automatic logic [IDX_W-1:0] lim_m1(input logic [CFG_W-1:0] dim);
    if (dim == '0) begin
      return '0;
    end else if (32'(dim) > MAX_DIM) begin
      return IDX_W'(MAX_DIM - 1);
    end else begin
      return IDX_W'(dim - 1'b1);
    end
  endfunction

  logic [CFG_W-1:0] rows_a, inner_dim, cols_b;
  state_t state, state_next;
  logic [IDX_W-1:0] r_idx, c_idx, k_idx;
  logic [IDX_W-1:0] nr_m1, nk_m1, nc_m1;
  logic rd_valid, prod_valid;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic out_valid, out_last;
  logic [ELEM_W-1:0] out_value;
  logic [POS_W-1:0]  out_row, out_col;

  logic in_fire, compute_start, wr_a, wr_b, wr_in_range, issue, emit_load, is_last;
  logic [ADDR_W-1:0] wr_addr, a_raddr, b_raddr;
  logic [ELEM_W-1:0] a_rdata, b_rdata;
  logic signed [PROD_W-1:0] prod_raw;
  logic signed [ACC_W-1:0]  prod_ext;
  logic [ACC_W-TOP_LO-1:0]  acc_top;
  logic [ELEM_W-1:0]        sat_value;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= CFG_W'(1);
      inner_dim <= CFG_W'(1);
      cols_b    <= CFG_W'(1);
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_ROWS_A:    rows_a    <= cfg_data;
        CFG_INNER_DIM: inner_dim <= cfg_data;
        CFG_COLS_B:    cols_b    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign nr_m1 = lim_m1(rows_a);
  assign nk_m1 = lim_m1(inner_dim);
  assign nc_m1 = lim_m1(cols_b);

  // Sequencer outputs
  always_comb begin
    in_ch.ready = (state == ST_IDLE);
    issue       = (state == ST_MAC);
    is_last     = (r_idx == nr_m1) && (c_idx == nc_m1);
    emit_load   = (state == ST_EMIT) && (!out_valid || out_ch.ready);
  end

  assign in_fire       = in_ch.valid && in_ch.ready;
  assign compute_start = in_fire && (op_t'(in_ch.op) == OP_COMPUTE);
  assign wr_in_range   = (32'(in_ch.row_index) < MAX_DIM) && (32'(in_ch.col_index) < MAX_DIM);
  assign wr_a = in_fire && (op_t'(in_ch.op) == OP_WRITE_A) && wr_in_range;
  assign wr_b = in_fire && (op_t'(in_ch.op) == OP_WRITE_B) && wr_in_range;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (compute_start) state_next = ST_MAC;
      ST_MAC:    if (k_idx == nk_m1) state_next = ST_FLUSH1;
      ST_FLUSH1: state_next = ST_FLUSH2;
      ST_FLUSH2: state_next = ST_EMIT;
      ST_EMIT:   if (emit_load) state_next = is_last ? ST_IDLE : ST_MAC;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Row, column and term counters
  always_ff @(posedge clk) begin
    if (rst) begin
      r_idx <= '0;
      c_idx <= '0;
      k_idx <= '0;
    end else if (compute_start) begin
      r_idx <= '0;
      c_idx <= '0;
      k_idx <= '0;
    end else if (issue) begin
      k_idx <= (k_idx == nk_m1) ? '0 : k_idx + 1'b1;
    end else if (emit_load) begin
      if (c_idx == nc_m1) begin
        c_idx <= '0;
        r_idx <= r_idx + 1'b1;
      end else begin
        c_idx <= c_idx + 1'b1;
      end
    end
  end

  // Element stores
  assign wr_addr = ADDR_W'(in_ch.row_index * MAX_DIM + in_ch.col_index);
  assign a_raddr = ADDR_W'(r_idx * MAX_DIM + k_idx);
  assign b_raddr = ADDR_W'(k_idx * MAX_DIM + c_idx);

  mmu_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_store_a (
    .clk(clk), .we(wr_a), .waddr(wr_addr), .wdata(in_ch.elem_value),
    .raddr(a_raddr), .rdata(a_rdata)
  );

  mmu_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_store_b (
    .clk(clk), .we(wr_b), .waddr(wr_addr), .wdata(in_ch.elem_value),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  // Shared multiplier, registered product
  assign prod_raw = signed'(a_rdata) * signed'(b_rdata);
  assign prod_ext = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      rd_valid   <= issue;
      prod_valid <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod <= prod_raw;
  end

  // Exact accumulator, cleared between elements
  always_ff @(posedge clk) begin
    if (state == ST_IDLE || emit_load) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + prod_ext;
    end
  end

  // Drop 16 fraction bits, saturate to 32 bits
  assign acc_top = acc[ACC_W-1:TOP_LO];
  always_comb begin
    if ((&acc_top) || !(|acc_top)) begin
      sat_value = acc[TOP_LO:FRAC_W];
    end else if (acc[ACC_W-1]) begin
      sat_value = {1'b1, {(ELEM_W-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(ELEM_W-1){1'b1}}};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_value <= sat_value;
      out_row   <= POS_W'(r_idx);
      out_col   <= POS_W'(c_idx);
      out_last  <= is_last;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.prod_value = out_value;
  assign out_ch.prod_row   = out_row;
  assign out_ch.prod_col   = out_col;
  assign out_ch.last_elem  = out_last;

  // The pipeline is empty whenever new items are taken
  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> (!rd_valid && !prod_valid))
    else $error("input taken with products still in flight");

  // A result is only formed after the final product was added
  a_emit_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (!rd_valid && !prod_valid))
    else $error("result formed before accumulation finished");

  // The final element of a product returns the block to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (emit_load && is_last) |=> (state == ST_IDLE && out_ch.valid && out_ch.last_elem))
    else $error("last element did not end the compute");

  // Term counter stays within the dot product length
  a_k_range: assert property (@(posedge clk) disable iff (rst)
    issue |-> (k_idx <= nk_m1))
    else $error("term index beyond inner dimension");

endmodule
